// File: rtl/script_lexer_token_scanner_unit_assert.svh
// ---------------------------------------------------------------------------
// script lexer assertion macros
// shared concurrent assertion forms for the token scanner
// ---------------------------------------------------------------------------
`ifndef SCRIPT_LEXER_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SCRIPT_LEXER_TOKEN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// next-cycle implication
`define SLTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

// File: rtl/slts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// script lexer package
// token codes, scan modes and keyword lookup for the token scanner
// ---------------------------------------------------------------------------
package slts_pkg;

   localparam int OFFSET_BITS_DEF = 24;
   localparam int LINE_BITS_DEF   = 20;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [5:0] TK_LPAREN = 6'd0;
   localparam logic [5:0] TK_RPAREN = 6'd1;
   localparam logic [5:0] TK_LBRACE = 6'd2;
   localparam logic [5:0] TK_RBRACE = 6'd3;
   localparam logic [5:0] TK_COMMA  = 6'd4;
   localparam logic [5:0] TK_DOT    = 6'd5;
   localparam logic [5:0] TK_MINUS  = 6'd6;
   localparam logic [5:0] TK_PLUS   = 6'd7;
   localparam logic [5:0] TK_SEMI   = 6'd8;
   localparam logic [5:0] TK_SLASH  = 6'd9;
   localparam logic [5:0] TK_STAR   = 6'd10;
   localparam logic [5:0] TK_BANG   = 6'd11;
   localparam logic [5:0] TK_EQ     = 6'd13;
   localparam logic [5:0] TK_GT     = 6'd15;
   localparam logic [5:0] TK_LT     = 6'd17;
   localparam logic [5:0] TK_IDENT  = 6'd19;
   localparam logic [5:0] TK_STR    = 6'd20;
   localparam logic [5:0] TK_NUM    = 6'd21;
   localparam logic [5:0] TK_AND    = 6'd22;
   localparam logic [5:0] TK_CLASS  = 6'd23;
   localparam logic [5:0] TK_ELSE   = 6'd24;
   localparam logic [5:0] TK_FALSE  = 6'd25;
   localparam logic [5:0] TK_FOR    = 6'd26;
   localparam logic [5:0] TK_FUN    = 6'd27;
   localparam logic [5:0] TK_IF     = 6'd28;
   localparam logic [5:0] TK_NIL    = 6'd29;
   localparam logic [5:0] TK_OR     = 6'd30;
   localparam logic [5:0] TK_PRINT  = 6'd31;
   localparam logic [5:0] TK_RETURN = 6'd32;
   localparam logic [5:0] TK_SUPER  = 6'd33;
   localparam logic [5:0] TK_THIS   = 6'd34;
   localparam logic [5:0] TK_TRUE   = 6'd35;
   localparam logic [5:0] TK_VAR    = 6'd36;
   localparam logic [5:0] TK_WHILE  = 6'd37;
   localparam logic [5:0] TK_ERR    = 6'd38;
   localparam logic [5:0] TK_EOF    = 6'd39;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_STRING = 2'd1;
   localparam logic [1:0] ERR_CHAR   = 2'd2;

   localparam logic [3:0] M_IDLE = 4'd0;
   localparam logic [3:0] M_WORD = 4'd1;
   localparam logic [3:0] M_INT  = 4'd2;
   localparam logic [3:0] M_DOT  = 4'd3;
   localparam logic [3:0] M_FRAC = 4'd4;
   localparam logic [3:0] M_STR  = 4'd5;
   localparam logic [3:0] M_OP   = 4'd6;
   localparam logic [3:0] M_NOTE = 4'd7;

   // packed word prefix, last byte in the low bits
   function automatic logic [5:0] kw_code(input logic [47:0] p);
      logic [5:0] k;
      case (p)
         48'h0000_0061_6e64: k = TK_AND;
         48'h0063_6c61_7373: k = TK_CLASS;
         48'h0000_656c_7365: k = TK_ELSE;
         48'h0066_616c_7365: k = TK_FALSE;
         48'h0000_0066_6f72: k = TK_FOR;
         48'h0000_0066_756e: k = TK_FUN;
         48'h0000_0000_6966: k = TK_IF;
         48'h0000_006e_696c: k = TK_NIL;
         48'h0000_0000_6f72: k = TK_OR;
         48'h0070_7269_6e74: k = TK_PRINT;
         48'h7265_7475_726e: k = TK_RETURN;
         48'h0073_7570_6572: k = TK_SUPER;
         48'h0000_7468_6973: k = TK_THIS;
         48'h0000_7472_7565: k = TK_TRUE;
         48'h0000_0076_6172: k = TK_VAR;
         48'h0077_6869_6c65: k = TK_WHILE;
         default:            k = TK_IDENT;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/slts_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// script lexer channels
// source byte channel and token channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface slts_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] ch;
   modport source (output valid, kind, ch, input ready);
   modport sink (input valid, kind, ch, output ready);
endinterface

interface slts_rsp_if #(
   parameter int OFFSET_BITS = slts_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = slts_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = slts_pkg::LENGTH_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [5:0]             token_kind;
   logic [OFFSET_BITS-1:0] token_start;
   logic [LENGTH_BITS-1:0] token_length;
   logic [LINE_BITS-1:0]   line_number;
   logic [1:0]             error_kind;
   logic                   last_of_run;
   modport source (output valid, token_kind, token_start, token_length, line_number,
                   error_kind, last_of_run, input ready);
   modport sink (input valid, token_kind, token_start, token_length, line_number,
                 error_kind, last_of_run, output ready);
endinterface

// File: rtl/slts_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// script lexer front
// one-byte lookahead scanner, packs up to three tokens per byte
// ---------------------------------------------------------------------------
`include "script_lexer_token_scanner_unit_assert.svh"

module slts_front #(
   parameter int OB = slts_pkg::OFFSET_BITS_DEF,
   parameter int LB = slts_pkg::LINE_BITS_DEF,
   parameter int NB = slts_pkg::LENGTH_BITS_DEF,
   parameter int BW = 2 + 3 * (8 + OB + LB + NB)
) (
   input  logic          clock,
   input  logic          reset,
   slts_req_if.sink      req,
   input  logic          q_full,
   output logic          push,
   output logic [BW-1:0] bundle
);

   typedef struct packed {
      logic [5:0]    kind;
      logic [OB-1:0] start;
      logic [NB-1:0] len;
      logic [LB-1:0] line;
      logic [1:0]    err;
   } tok_type;

   logic [3:0]    mode_ff, mode_in;
   logic [OB-1:0] begin_ff, begin_in;
   logic [OB-1:0] pos_ff, pos_in;
   logic [LB-1:0] line_ff, line_in;
   logic [47:0]   prefix_ff, prefix_in;
   logic          long_ff, long_in;
   logic [NB-1:0] run_ff, run_in;
   logic [5:0]    op_ff, op_in;

   tok_type [2:0] toks;
   logic [1:0]    n;
   logic          accept, is_end, is_dig, is_wst, consumed;
   logic [7:0]    c;
   logic [NB-1:0] run_inc;

   function automatic tok_type mk(input logic [5:0] k, input logic [OB-1:0] s,
                                  input logic [NB-1:0] l, input logic [1:0] e,
                                  input logic [LB-1:0] ln);
      tok_type t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.line  = ln;
      t.err   = e;
      return t;
   endfunction

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.ch;
   assign is_end    = req.kind || (c == 8'h00);
   assign is_dig    = (c >= 8'h30) && (c <= 8'h39);
   assign is_wst    = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
                      || (c == 8'h5f);
   assign run_inc   = (run_ff == {NB{1'b1}}) ? run_ff : run_ff + NB'(1);

   always_comb begin
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      long_in   = long_ff;
      run_in    = run_ff;
      op_in     = op_ff;
      toks      = '0;
      n         = 2'd0;
      consumed  = 1'b0;
      if (!is_end) begin
         case (mode_ff)
            slts_pkg::M_WORD: begin
               if (is_wst || is_dig) begin
                  if (prefix_ff[47:40] != 8'h00) long_in = 1'b1;
                  prefix_in = {prefix_ff[39:0], c};
                  run_in    = run_inc;
                  consumed  = 1'b1;
               end
            end
            slts_pkg::M_INT: begin
               if (is_dig) begin
                  run_in   = run_inc;
                  consumed = 1'b1;
               end else if (c == 8'h2e) begin
                  mode_in  = slts_pkg::M_DOT;
                  consumed = 1'b1;
               end
            end
            slts_pkg::M_DOT: begin
               if (is_dig) begin
                  run_in   = (run_ff >= {NB{1'b1}} - NB'(1)) ? {NB{1'b1}} : run_ff + NB'(2);
                  mode_in  = slts_pkg::M_FRAC;
                  consumed = 1'b1;
               end
            end
            slts_pkg::M_FRAC: begin
               if (is_dig) begin
                  run_in   = run_inc;
                  consumed = 1'b1;
               end
            end
            slts_pkg::M_STR: begin
               run_in   = run_inc;
               consumed = 1'b1;
               if (c == 8'h22) begin
                  toks[n] = mk(slts_pkg::TK_STR, begin_ff, run_inc, slts_pkg::ERR_NONE, line_ff);
                  n       = n + 2'd1;
                  mode_in = slts_pkg::M_IDLE;
               end else if (c == 8'h0a) begin
                  line_in = (line_ff == {LB{1'b1}}) ? line_ff : line_ff + LB'(1);
               end
            end
            slts_pkg::M_OP: begin
               if (c == 8'h3d) begin
                  toks[n]  = mk(op_ff + 6'd1, begin_ff, NB'(2), slts_pkg::ERR_NONE, line_ff);
                  n        = n + 2'd1;
                  mode_in  = slts_pkg::M_IDLE;
                  consumed = 1'b1;
               end
            end
            slts_pkg::M_NOTE: begin
               if (c != 8'h0a) consumed = 1'b1;
               else mode_in = slts_pkg::M_IDLE;
            end
            default: mode_in = slts_pkg::M_IDLE;
         endcase
      end
      // emit the held token
      if (is_end || !consumed) begin
         case (mode_ff)
            slts_pkg::M_WORD: begin
               toks[n] = mk(long_ff ? slts_pkg::TK_IDENT : slts_pkg::kw_code(prefix_ff),
                            begin_ff, run_ff, slts_pkg::ERR_NONE, line_ff);
               n       = n + 2'd1;
            end
            slts_pkg::M_INT, slts_pkg::M_FRAC: begin
               toks[n] = mk(slts_pkg::TK_NUM, begin_ff, run_ff, slts_pkg::ERR_NONE, line_ff);
               n       = n + 2'd1;
            end
            slts_pkg::M_DOT: begin
               toks[n] = mk(slts_pkg::TK_NUM, begin_ff, run_ff, slts_pkg::ERR_NONE, line_ff);
               n       = n + 2'd1;
               toks[n] = mk(slts_pkg::TK_DOT, pos_ff - OB'(1), NB'(1), slts_pkg::ERR_NONE,
                            line_ff);
               n       = n + 2'd1;
            end
            slts_pkg::M_STR: begin
               if (is_end) begin
                  toks[n] = mk(slts_pkg::TK_ERR, begin_ff, run_ff, slts_pkg::ERR_STRING,
                               line_ff);
                  n       = n + 2'd1;
               end
            end
            slts_pkg::M_OP: begin
               toks[n] = mk(op_ff, begin_ff, NB'(1), slts_pkg::ERR_NONE, line_ff);
               n       = n + 2'd1;
            end
            default: ;
         endcase
         mode_in = slts_pkg::M_IDLE;
      end
      if (is_end) begin
         toks[n] = mk(slts_pkg::TK_EOF, pos_ff, NB'(0), slts_pkg::ERR_NONE, line_ff);
         n       = n + 2'd1;
      end else begin
         pos_in = pos_ff + OB'(1);
         if (!consumed) begin
            case (c)
               8'h20, 8'h0d, 8'h09: ;
               8'h0a: line_in = (line_ff == {LB{1'b1}}) ? line_ff : line_ff + LB'(1);
               8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2c, 8'h2e, 8'h2d, 8'h2b, 8'h3b, 8'h2f,
               8'h2a: begin
                  case (c)
                     8'h28:   toks[n].kind = slts_pkg::TK_LPAREN;
                     8'h29:   toks[n].kind = slts_pkg::TK_RPAREN;
                     8'h7b:   toks[n].kind = slts_pkg::TK_LBRACE;
                     8'h7d:   toks[n].kind = slts_pkg::TK_RBRACE;
                     8'h2c:   toks[n].kind = slts_pkg::TK_COMMA;
                     8'h2e:   toks[n].kind = slts_pkg::TK_DOT;
                     8'h2d:   toks[n].kind = slts_pkg::TK_MINUS;
                     8'h2b:   toks[n].kind = slts_pkg::TK_PLUS;
                     8'h3b:   toks[n].kind = slts_pkg::TK_SEMI;
                     8'h2f:   toks[n].kind = slts_pkg::TK_SLASH;
                     default: toks[n].kind = slts_pkg::TK_STAR;
                  endcase
                  toks[n].start = pos_ff;
                  toks[n].len   = NB'(1);
                  toks[n].line  = line_ff;
                  toks[n].err   = slts_pkg::ERR_NONE;
                  n             = n + 2'd1;
               end
               8'h21, 8'h3d, 8'h3e, 8'h3c: begin
                  mode_in  = slts_pkg::M_OP;
                  begin_in = pos_ff;
                  run_in   = NB'(1);
                  case (c)
                     8'h21:   op_in = slts_pkg::TK_BANG;
                     8'h3d:   op_in = slts_pkg::TK_EQ;
                     8'h3e:   op_in = slts_pkg::TK_GT;
                     default: op_in = slts_pkg::TK_LT;
                  endcase
               end
               8'h22: begin
                  mode_in  = slts_pkg::M_STR;
                  begin_in = pos_ff;
                  run_in   = NB'(1);
               end
               8'h23: mode_in = slts_pkg::M_NOTE;
               default: begin
                  if (is_wst) begin
                     mode_in   = slts_pkg::M_WORD;
                     begin_in  = pos_ff;
                     run_in    = NB'(1);
                     prefix_in = {40'h0, c};
                     long_in   = 1'b0;
                  end else if (is_dig) begin
                     mode_in  = slts_pkg::M_INT;
                     begin_in = pos_ff;
                     run_in   = NB'(1);
                  end else begin
                     toks[n] = mk(slts_pkg::TK_ERR, pos_ff, NB'(1), slts_pkg::ERR_CHAR,
                                  line_ff);
                     n       = n + 2'd1;
                  end
               end
            endcase
         end
      end
   end

   assign push   = accept && (n != 2'd0);
   assign bundle = {n, toks};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= slts_pkg::M_IDLE;
         begin_ff  <= '0;
         pos_ff    <= '0;
         line_ff   <= LB'(1);
         prefix_ff <= '0;
         long_ff   <= 1'b0;
         run_ff    <= '0;
         op_ff     <= slts_pkg::TK_BANG;
      end else if (accept) begin
         mode_ff   <= mode_in;
         begin_ff  <= begin_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         long_ff   <= long_in;
         run_ff    <= run_in;
         op_ff     <= op_in;
      end
   end

   `SLTS_ASSERT_NEXT(a_end_idle, clock, reset, accept && is_end, mode_ff == slts_pkg::M_IDLE)
   `SLTS_ASSERT_NEXT(a_end_pos, clock, reset, accept && is_end, pos_ff == $past(pos_ff))
   `SLTS_ASSERT_NEXT(a_pos_step, clock, reset, accept && !is_end,
                     pos_ff == $past(pos_ff) + OB'(1))

endmodule

// File: rtl/slts_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// script lexer back
// token bundle queue and one-token-per-transaction output register
// ---------------------------------------------------------------------------
`include "script_lexer_token_scanner_unit_assert.svh"

module slts_back #(
   parameter int OB = slts_pkg::OFFSET_BITS_DEF,
   parameter int LB = slts_pkg::LINE_BITS_DEF,
   parameter int NB = slts_pkg::LENGTH_BITS_DEF,
   parameter int BW = 2 + 3 * (8 + OB + LB + NB)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [BW-1:0] bundle,
   output logic          q_full,
   slts_rsp_if.source    rsp
);

   localparam int DEPTH = slts_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   typedef struct packed {
      logic [5:0]    kind;
      logic [OB-1:0] start;
      logic [NB-1:0] len;
      logic [LB-1:0] line;
      logic [1:0]    err;
   } tok_type;

   typedef struct packed {
      logic [1:0]    cnt;
      tok_type [2:0] toks;
   } bundle_type;

   logic [BW-1:0] q_mem [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   count_ff, count_in;
   bundle_type    cur_ff;
   logic [1:0]    idx_ff;
   logic          valid_ff;
   logic          last, pop, fire;
   tok_type       t;

   assign q_full = (count_ff == (PW + 1)'(DEPTH));
   assign last   = (idx_ff == cur_ff.cnt - 2'd1);
   assign fire   = valid_ff && rsp.ready;
   assign pop    = (count_ff != '0) && (!valid_ff || (fire && last));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (PW + 1)'(1);
      else if (pop && !push) count_in = count_ff - (PW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ff] <= bundle;
      if (pop) cur_ff <= bundle_type'(q_mem[rd_ff]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + PW'(1);
         if (pop) begin
            rd_ff    <= rd_ff + PW'(1);
            valid_ff <= 1'b1;
            idx_ff   <= 2'd0;
         end else if (fire) begin
            if (last) valid_ff <= 1'b0;
            else idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   assign t                = cur_ff.toks[idx_ff];
   assign rsp.valid        = valid_ff;
   assign rsp.token_kind   = t.kind;
   assign rsp.token_start  = t.start;
   assign rsp.token_length = t.len;
   assign rsp.line_number  = t.line;
   assign rsp.error_kind   = t.err;
   assign rsp.last_of_run  = last;

   `SLTS_ASSERT_NOW(a_no_overflow, clock, reset, push, !q_full)
   `SLTS_ASSERT_NOW(a_cnt_nonzero, clock, reset, valid_ff, cur_ff.cnt != 2'd0)
   `SLTS_ASSERT_NOW(a_idx_range, clock, reset, valid_ff, idx_ff < cur_ff.cnt)

endmodule

// File: rtl/script_lexer_token_scanner_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// script lexer token scanner
// streaming lexer: one source byte per transaction in, tokens out
// ---------------------------------------------------------------------------
// A source byte is taken every cycle while the four-entry token queue has
// room; each byte yields zero to three tokens, and the output side sends one
// token per cycle while the consumer is ready, so the sustained byte rate is
// set by the token count that the output register drains. A token reaches the
// output after its bundle is written to the queue and then loaded into the output register.
module script_lexer_token_scanner_unit #(
   parameter int OFFSET_BITS = slts_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = slts_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = slts_pkg::LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   slts_req_if.sink   req_chan,
   slts_rsp_if.source rsp_chan
);

   localparam int BW = 2 + 3 * (8 + OFFSET_BITS + LINE_BITS + LENGTH_BITS);

   logic          push;
   logic          q_full;
   logic [BW-1:0] bundle;

   slts_front #(
      .OB(OFFSET_BITS), .LB(LINE_BITS), .NB(LENGTH_BITS), .BW(BW)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .push   (push),
      .bundle (bundle)
   );

   slts_back #(
      .OB(OFFSET_BITS), .LB(LINE_BITS), .NB(LENGTH_BITS), .BW(BW)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .bundle (bundle),
      .q_full (q_full),
      .rsp    (rsp_chan)
   );

endmodule
